@@ sv/pfa_pkg.sv @@
// Shared types and constants of the partition fit allocator.
package pfa_pkg;

    localparam int PARTS     = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_W     = (PARTS > 1) ? $clog2(PARTS) : 1;
    localparam int CNT_W     = $clog2(PARTS + 1);
    localparam int SLOT_W    = 4;
    localparam int FIELD_W   = 16;
    localparam int TOT_W     = 20;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } t_fit_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

@@ sv/partition_fit_allocator_unit.sv @@
// Fixed-partition allocator: first, next, best and worst fit over a partition table.
//
// Input channel (i_valid / o_ready) takes one item: a load (operation 0) writes a
// partition size and marks it free; an allocate (operation 1) looks for a free
// partition at least as large as the job. Output channel (o_valid / i_ready) returns
// one result per item: grant flag, slot, slot waste and saturating running totals.
// Configuration: i_cfg_we with i_cfg_idx (0 fit mode, 1 partition count) and
// i_cfg_data, to be written by the user only while the block is idle; the block does not enforce it.
// A load writes the table on accept and passes through the finish step to the output
// register. An allocate scans the partitions from the start index: one subtract/compare
// unit visits one partition per cycle, up to the partition count clamped to 16, then
// passes through the finish step. First and next fit stop at the first hit.
// One item is in work at a time; o_ready is high only while the sequencer is idle.
// A finished result sits in the output register until taken; while it waits the
// next item can be accepted and scanned, and its result holds in the finish step
// until the output register frees.
// Synchronous reset clears all partitions to free, the totals, the next-fit start,
// fit mode and partition count. Partition sizes are not cleared.
module partition_fit_allocator_unit
    import pfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_operation,
    input  logic [SLOT_W-1:0]    i_slot_index,
    input  logic [FIELD_W-1:0]   i_size_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_granted,
    output logic [SLOT_W-1:0]    o_granted_slot,
    output logic [FIELD_W-1:0]   o_slot_waste,
    output logic [TOT_W-1:0]     o_used_sum,
    output logic [TOT_W-1:0]     o_waste_sum
);

    // control state
    t_state                r_state, n_state;
    t_fit_mode             r_fit_mode;
    logic [CFG_DAT_W-1:0]  r_part_count;
    logic [PARTS-1:0]      r_busy, n_busy;
    logic [IDX_W-1:0]      r_scan_start, n_scan_start;
    logic [TOT_W-1:0]      r_used_total, n_used_total;
    logic [TOT_W-1:0]      r_waste_total, n_waste_total;
    logic                  r_out_valid, n_out_valid;
    logic                  r_found, n_found;

    // payload
    logic [SIZE_BITS-1:0]  r_part_size [PARTS];
    logic [SIZE_BITS-1:0]  r_job, n_job;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_step, n_step;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_pick, n_pick;
    logic [SIZE_BITS-1:0]  r_best, n_best;
    logic                  r_out_granted, n_out_granted;
    logic [SLOT_W-1:0]     r_out_slot, n_out_slot;
    logic [FIELD_W-1:0]    r_out_waste, n_out_waste;
    logic [TOT_W-1:0]      r_out_used, n_out_used;
    logic [TOT_W-1:0]      r_out_wsum, n_out_wsum;

    logic                  accept;
    logic                  load_wr;
    logic [CNT_W-1:0]      cnt_clamp;
    logic [CNT_W-1:0]      idx_inc;
    logic [SIZE_BITS:0]    diff;
    logic [SIZE_BITS-1:0]  left;
    logic                  fit;
    logic                  better;
    logic                  out_free;
    logic [TOT_W:0]        used_add;
    logic [TOT_W:0]        waste_add;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign load_wr  = accept && (i_operation == OP_LOAD) && (int'(i_slot_index) < PARTS);
    assign out_free = !r_out_valid || i_ready;

    assign cnt_clamp = (int'(r_part_count) > PARTS) ? CNT_W'(PARTS) : CNT_W'(r_part_count);
    assign idx_inc   = CNT_W'(r_idx) + CNT_W'(1);

    // shared unit: one subtract gives fit and leftover, one compare ranks it
    assign diff   = {1'b0, r_part_size[r_idx]} - {1'b0, r_job};
    assign left   = diff[SIZE_BITS-1:0];
    assign fit    = !r_busy[r_idx] && !diff[SIZE_BITS];
    assign better = !r_found
                 || ((r_fit_mode == FIT_BEST)  && (left < r_best))
                 || ((r_fit_mode == FIT_WORST) && (left > r_best));

    assign used_add  = {1'b0, r_used_total}  + (TOT_W+1)'(r_job);
    assign waste_add = {1'b0, r_waste_total} + (TOT_W+1)'(r_best);

    always_comb begin
        n_state       = r_state;
        n_busy        = r_busy;
        n_scan_start  = r_scan_start;
        n_used_total  = r_used_total;
        n_waste_total = r_waste_total;
        n_out_valid   = r_out_valid && !i_ready;
        n_found       = r_found;
        n_job         = r_job;
        n_idx         = r_idx;
        n_step        = r_step;
        n_count       = r_count;
        n_pick        = r_pick;
        n_best        = r_best;
        n_out_granted = r_out_granted;
        n_out_slot    = r_out_slot;
        n_out_waste   = r_out_waste;
        n_out_used    = r_out_used;
        n_out_wsum    = r_out_wsum;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_job   = SIZE_BITS'(i_size_value);
                    n_found = 1'b0;
                    n_step  = '0;
                    n_count = cnt_clamp;
                    n_pick  = '0;
                    n_best  = '0;
                    if (r_fit_mode == FIT_NEXT && CNT_W'(r_scan_start) < cnt_clamp) begin
                        n_idx = r_scan_start;
                    end else begin
                        n_idx = '0;
                    end
                    if (i_operation == OP_LOAD) begin
                        if (load_wr) begin
                            n_busy[IDX_W'(i_slot_index)] = 1'b0;
                        end
                        n_state = S_FINISH;
                    end else if (cnt_clamp == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (fit && better) begin
                    n_found = 1'b1;
                    n_pick  = r_idx;
                    n_best  = left;
                end
                n_idx  = (idx_inc == r_count) ? '0 : idx_inc[IDX_W-1:0];
                n_step = r_step + CNT_W'(1);
                if ((fit && (r_fit_mode == FIT_FIRST || r_fit_mode == FIT_NEXT))
                        || (r_step == r_count - CNT_W'(1))) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    if (r_found) begin
                        n_busy[r_pick] = 1'b1;
                        n_used_total  = used_add[TOT_W]  ? '1 : used_add[TOT_W-1:0];
                        n_waste_total = waste_add[TOT_W] ? '1 : waste_add[TOT_W-1:0];
                        if (r_fit_mode == FIT_NEXT) begin
                            n_scan_start = (r_pick == IDX_W'(PARTS - 1)) ? '0
                                         : r_pick + IDX_W'(1);
                        end
                    end
                    n_out_valid   = 1'b1;
                    n_out_granted = r_found;
                    n_out_slot    = r_found ? SLOT_W'(r_pick) : '0;
                    n_out_waste   = r_found ? FIELD_W'(r_best) : '0;
                    n_out_used    = n_used_total;
                    n_out_wsum    = n_waste_total;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fit_mode    <= FIT_FIRST;
            r_part_count  <= '0;
            r_busy        <= '0;
            r_scan_start  <= '0;
            r_used_total  <= '0;
            r_waste_total <= '0;
            r_out_valid   <= 1'b0;
            r_found       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_busy        <= n_busy;
            r_scan_start  <= n_scan_start;
            r_used_total  <= n_used_total;
            r_waste_total <= n_waste_total;
            r_out_valid   <= n_out_valid;
            r_found       <= n_found;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FIT_MODE:   r_fit_mode   <= t_fit_mode'(i_cfg_data[1:0]);
                    REG_PART_COUNT: r_part_count <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job         <= n_job;
        r_idx         <= n_idx;
        r_step        <= n_step;
        r_count       <= n_count;
        r_pick        <= n_pick;
        r_best        <= n_best;
        r_out_granted <= n_out_granted;
        r_out_slot    <= n_out_slot;
        r_out_waste   <= n_out_waste;
        r_out_used    <= n_out_used;
        r_out_wsum    <= n_out_wsum;
        if (load_wr) begin
            r_part_size[IDX_W'(i_slot_index)] <= SIZE_BITS'(i_size_value);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_granted      = r_out_granted;
    assign o_granted_slot = r_out_slot;
    assign o_slot_waste   = r_out_waste;
    assign o_used_sum     = r_out_used;
    assign o_waste_sum    = r_out_wsum;

    // a grant marks its partition busy
    a_grant_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && out_free && r_found) |=> r_busy[$past(r_pick)])
        else $error("granted partition not marked busy");

    // scan never runs past the partition count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_step < r_count && r_count != '0))
        else $error("scan step out of range");

    // totals never decrease
    a_totals_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_used_total >= $past(r_used_total)
                         && r_waste_total >= $past(r_waste_total)))
        else $error("running total decreased");

    // a refused or load result carries no slot and no waste
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_granted) |-> (o_granted_slot == '0 && o_slot_waste == '0))
        else $error("refused result with nonzero slot or waste");

endmodule
